@@ rtl/average_cost_position_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the average-cost position tracker
// Implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef AVERAGE_COST_POSITION_TRACKER_ASSERT_SVH
`define AVERAGE_COST_POSITION_TRACKER_ASSERT_SVH

// same-cycle implication
`define ACT_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("act assertion failed");

// next-cycle implication
`define ACT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("act assertion failed");

`endif

@@ rtl/act_pkg.sv @@
// ----------------------------------------------------------------------------
// act_pkg
// Types, codes and helpers shared by the position tracker modules.
// ----------------------------------------------------------------------------
package act_pkg;

   localparam logic [1:0] CMD_ADD_ID = 2'd0;
   localparam logic [1:0] CMD_TRADE  = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_RESET  = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_IDLE         = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD         = 5'd1;
   localparam logic [OP_W-1:0] OP_ADD_ID       = 5'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_IDS    = 5'd3;
   localparam logic [OP_W-1:0] OP_RESET_ALL    = 5'd4;
   localparam logic [OP_W-1:0] OP_SCAN_START   = 5'd5;
   localparam logic [OP_W-1:0] OP_SCAN_STEP    = 5'd6;
   localparam logic [OP_W-1:0] OP_CLOSE_PREP   = 5'd7;
   localparam logic [OP_W-1:0] OP_MUL_PNL      = 5'd8;
   localparam logic [OP_W-1:0] OP_ADD_PNL      = 5'd9;
   localparam logic [OP_W-1:0] OP_CASH_CLOSE   = 5'd10;
   localparam logic [OP_W-1:0] OP_MUL_REST     = 5'd11;
   localparam logic [OP_W-1:0] OP_CASH_REST    = 5'd12;
   localparam logic [OP_W-1:0] OP_MUL_HELD     = 5'd13;
   localparam logic [OP_W-1:0] OP_MUL_QTY      = 5'd14;
   localparam logic [OP_W-1:0] OP_OPEN_ADD     = 5'd15;
   localparam logic [OP_W-1:0] OP_DIV_STEP     = 5'd16;
   localparam logic [OP_W-1:0] OP_SET_AVG      = 5'd17;
   localparam logic [OP_W-1:0] OP_FIN_TRADE    = 5'd18;
   localparam logic [OP_W-1:0] OP_WRITE_RSP    = 5'd19;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] own_order_id;
      logic [31:0] buyer_order_id;
      logic [31:0] seller_order_id;
      logic [23:0] trade_quantity;
      logic [23:0] trade_price;
   } act_req_type;

   typedef struct packed {
      logic               matched;
      logic               was_buy;
      logic signed [31:0] position_quantity;
      logic [31:0]        average_price;
      logic signed [63:0] realized_profit;
      logic signed [63:0] cash_balance;
      logic [31:0]        fill_count;
      logic [47:0]        traded_volume;
      logic [1:0]         status;
   } act_rsp_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } act_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       qty_zero;
      logic       found;
      logic       miss;
      logic       closing;
      logic       rest_nz;
      logic       div_last;
   } act_stat_type;

   typedef struct packed {
      logic               sat;
      logic signed [63:0] value;
   } act_sat_type;

   function automatic act_sat_type sat_add(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
      logic signed [63:0] s;
      act_sat_type        r;
      s = a + b;
      r.sat = (a[63] == b[63]) && (s[63] != a[63]);
      if (r.sat) begin
         r.value = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         r.value = s;
      end
      return r;
   endfunction

endpackage

@@ rtl/act_ctrl.sv @@
// ----------------------------------------------------------------------------
// act_ctrl
// Sequencer: steps the datapath through scan, arithmetic and result write.
// ----------------------------------------------------------------------------
module act_ctrl
   import act_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  act_stat_type stat,
   output act_cmd_type  cmd
);

   localparam logic [4:0] ST_IDLE       = 5'd0;
   localparam logic [4:0] ST_DECODE     = 5'd1;
   localparam logic [4:0] ST_SCAN       = 5'd2;
   localparam logic [4:0] ST_CLOSE_PREP = 5'd3;
   localparam logic [4:0] ST_MUL_PNL    = 5'd4;
   localparam logic [4:0] ST_ADD_PNL    = 5'd5;
   localparam logic [4:0] ST_CASH_CLOSE = 5'd6;
   localparam logic [4:0] ST_MUL_REST   = 5'd7;
   localparam logic [4:0] ST_CASH_REST  = 5'd8;
   localparam logic [4:0] ST_MUL_HELD   = 5'd9;
   localparam logic [4:0] ST_MUL_QTY    = 5'd10;
   localparam logic [4:0] ST_OPEN_ADD   = 5'd11;
   localparam logic [4:0] ST_DIV        = 5'd12;
   localparam logic [4:0] ST_SET_AVG    = 5'd13;
   localparam logic [4:0] ST_FIN_TRADE  = 5'd14;
   localparam logic [4:0] ST_FINISH     = 5'd15;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_IDLE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (stat.cmd)
               CMD_ADD_ID: begin
                  cmd.op   = OP_ADD_ID;
                  state_in = ST_FINISH;
               end
               CMD_CLEAR: begin
                  cmd.op   = OP_CLEAR_IDS;
                  state_in = ST_FINISH;
               end
               CMD_RESET: begin
                  cmd.op   = OP_RESET_ALL;
                  state_in = ST_FINISH;
               end
               default: begin
                  if (stat.qty_zero) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.op   = OP_SCAN_START;
                     state_in = ST_SCAN;
                  end
               end
            endcase
         end
         ST_SCAN: begin
            if (stat.found) begin
               state_in = stat.closing ? ST_CLOSE_PREP : ST_MUL_HELD;
            end else if (stat.miss) begin
               state_in = ST_FINISH;
            end else begin
               cmd.op = OP_SCAN_STEP;
            end
         end
         ST_CLOSE_PREP: begin
            cmd.op   = OP_CLOSE_PREP;
            state_in = ST_MUL_PNL;
         end
         ST_MUL_PNL: begin
            cmd.op   = OP_MUL_PNL;
            state_in = ST_ADD_PNL;
         end
         ST_ADD_PNL: begin
            cmd.op   = OP_ADD_PNL;
            state_in = ST_CASH_CLOSE;
         end
         ST_CASH_CLOSE: begin
            cmd.op   = OP_CASH_CLOSE;
            state_in = stat.rest_nz ? ST_MUL_REST : ST_FIN_TRADE;
         end
         ST_MUL_REST: begin
            cmd.op   = OP_MUL_REST;
            state_in = ST_CASH_REST;
         end
         ST_CASH_REST: begin
            cmd.op   = OP_CASH_REST;
            state_in = ST_FIN_TRADE;
         end
         ST_MUL_HELD: begin
            cmd.op   = OP_MUL_HELD;
            state_in = ST_MUL_QTY;
         end
         ST_MUL_QTY: begin
            cmd.op   = OP_MUL_QTY;
            state_in = ST_OPEN_ADD;
         end
         ST_OPEN_ADD: begin
            cmd.op   = OP_OPEN_ADD;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (stat.div_last) begin
               state_in = ST_SET_AVG;
            end
         end
         ST_SET_AVG: begin
            cmd.op   = OP_SET_AVG;
            state_in = ST_FIN_TRADE;
         end
         ST_FIN_TRADE: begin
            cmd.op   = OP_FIN_TRADE;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_WRITE_RSP;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/act_dp.sv @@
// ----------------------------------------------------------------------------
// act_dp
// Datapath: id memory and scan, shared multiplier, saturating accumulators,
// radix-2 divider for the average price, result register.
// ----------------------------------------------------------------------------
module act_dp
   import act_pkg::*;
#(
   parameter int TABLE_DEPTH = 128
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [61:0]  csr_wr_data,
   input  act_req_type  req_data,
   input  act_cmd_type  cmd,
   output act_stat_type stat,
   output act_rsp_type  rsp_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);
   localparam logic signed [33:0] Q_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] Q_MIN = -34'sh0_8000_0000;

   logic [31:0]        id_mem [TABLE_DEPTH];
   logic [31:0]        rd_data_ff;
   act_req_type        item_ff;
   logic [61:0]        init_cash_ff;
   logic [CW-1:0]      id_count_ff, issue_ff;
   logic               pend_ff, matched_ff, buy_ff, sat_ff;
   logic [1:0]         status_ff;
   logic signed [33:0] q_ff;
   logic [31:0]        avg_ff;
   logic signed [63:0] real_ff, cash_ff, prod_ff;
   logic [31:0]        fills_ff;
   logic [47:0]        vol_ff;
   logic [23:0]        close_ff, rest_ff;
   logic [63:0]        tot_ff;
   logic [32:0]        dvs_ff, rem_ff;
   logic [31:0]        quo_ff;
   logic [4:0]         div_cnt_ff;
   act_rsp_type        rsp_ff;

   logic [31:0]        px;
   logic [23:0]        qty;
   logic signed [33:0] abs_q, abs_open, diff, mul_a, mul_b;
   logic signed [67:0] mul_p;
   logic [23:0]        close_val;
   logic signed [63:0] cash_delta;
   act_sat_type        pnl_sum, cash_sum;
   logic [33:0]        div_r;
   logic [63:0]        open_sum;
   logic [48:0]        vol_sum;

   assign px       = {item_ff.trade_price, 8'd0};
   assign qty      = item_ff.trade_quantity;
   assign abs_q    = buy_ff ? -q_ff : q_ff;
   assign abs_open = buy_ff ? q_ff : -q_ff;
   assign diff     = $signed({2'b00, avg_ff}) - $signed({2'b00, px});
   assign close_val = ($signed({10'd0, qty}) < abs_q) ? qty : abs_q[23:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_PNL: begin
            mul_a = $signed({10'd0, close_ff});
            mul_b = buy_ff ? diff : -diff;
         end
         OP_ADD_PNL: begin
            mul_a = $signed({10'd0, close_ff});
            mul_b = $signed({2'b00, px});
         end
         OP_MUL_REST: begin
            mul_a = $signed({10'd0, rest_ff});
            mul_b = $signed({2'b00, px});
         end
         OP_MUL_HELD: begin
            mul_a = abs_open;
            mul_b = $signed({2'b00, avg_ff});
         end
         OP_MUL_QTY: begin
            mul_a = $signed({10'd0, qty});
            mul_b = $signed({2'b00, px});
         end
         default: begin
         end
      endcase
   end

   assign mul_p      = mul_a * mul_b;
   assign cash_delta = buy_ff ? -prod_ff : prod_ff;
   assign pnl_sum    = sat_add(real_ff, prod_ff);
   assign cash_sum   = sat_add(cash_ff, cash_delta);
   assign div_r      = {rem_ff, quo_ff[31]};
   assign open_sum   = tot_ff + prod_ff;
   assign vol_sum    = {1'b0, vol_ff} + {25'd0, qty};

   // id memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.op == OP_ADD_ID && id_count_ff < DEPTH_CNT) begin
         id_mem[id_count_ff[AW-1:0]] <= item_ff.own_order_id;
      end
      rd_data_ff <= id_mem[issue_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         item_ff <= req_data;
      end
      prod_ff <= mul_p[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_cash_ff <= '0;
         id_count_ff  <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         matched_ff   <= 1'b0;
         buy_ff       <= 1'b0;
         sat_ff       <= 1'b0;
         status_ff    <= STATUS_OK;
         q_ff         <= '0;
         avg_ff       <= '0;
         real_ff      <= '0;
         cash_ff      <= '0;
         fills_ff     <= '0;
         vol_ff       <= '0;
         div_cnt_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            init_cash_ff <= csr_wr_data;
         end
         case (cmd.op)
            OP_LOAD: begin
               matched_ff <= 1'b0;
               buy_ff     <= 1'b0;
               sat_ff     <= 1'b0;
               status_ff  <= STATUS_OK;
            end
            OP_ADD_ID: begin
               if (id_count_ff < DEPTH_CNT) begin
                  id_count_ff <= id_count_ff + 1'b1;
               end else begin
                  status_ff <= STATUS_FULL;
               end
            end
            OP_CLEAR_IDS: begin
               id_count_ff <= '0;
            end
            OP_RESET_ALL: begin
               id_count_ff <= '0;
               q_ff        <= '0;
               avg_ff      <= '0;
               real_ff     <= '0;
               cash_ff     <= $signed({2'b00, init_cash_ff});
               fills_ff    <= '0;
               vol_ff      <= '0;
            end
            OP_SCAN_START: begin
               issue_ff <= '0;
               pend_ff  <= 1'b0;
            end
            OP_SCAN_STEP: begin
               if (!matched_ff) begin
                  if (issue_ff < id_count_ff) begin
                     issue_ff <= issue_ff + 1'b1;
                     pend_ff  <= 1'b1;
                  end else begin
                     pend_ff <= 1'b0;
                  end
                  // buyer side wins on the same entry
                  if (pend_ff && rd_data_ff == item_ff.buyer_order_id) begin
                     matched_ff <= 1'b1;
                     buy_ff     <= 1'b1;
                  end else if (pend_ff && rd_data_ff == item_ff.seller_order_id) begin
                     matched_ff <= 1'b1;
                     buy_ff     <= 1'b0;
                  end
               end
            end
            OP_CLOSE_PREP: begin
               close_ff <= close_val;
               rest_ff  <= qty - close_val;
            end
            OP_ADD_PNL: begin
               real_ff <= pnl_sum.value;
               sat_ff  <= sat_ff | pnl_sum.sat;
            end
            OP_CASH_CLOSE: begin
               cash_ff <= cash_sum.value;
               sat_ff  <= sat_ff | cash_sum.sat;
               q_ff    <= buy_ff ? q_ff + $signed({10'd0, close_ff})
                                 : q_ff - $signed({10'd0, close_ff});
            end
            OP_CASH_REST: begin
               cash_ff <= cash_sum.value;
               sat_ff  <= sat_ff | cash_sum.sat;
               avg_ff  <= px;
               q_ff    <= buy_ff ? q_ff + $signed({10'd0, rest_ff})
                                 : q_ff - $signed({10'd0, rest_ff});
            end
            OP_MUL_QTY: begin
               tot_ff <= prod_ff;
            end
            OP_OPEN_ADD: begin
               cash_ff    <= cash_sum.value;
               sat_ff     <= sat_ff | cash_sum.sat;
               q_ff       <= buy_ff ? q_ff + $signed({10'd0, qty})
                                    : q_ff - $signed({10'd0, qty});
               dvs_ff     <= 33'(abs_open + $signed({10'd0, qty}));
               rem_ff     <= {1'b0, open_sum[63:32]};
               quo_ff     <= open_sum[31:0];
               div_cnt_ff <= '0;
            end
            OP_DIV_STEP: begin
               if (div_r >= {1'b0, dvs_ff}) begin
                  rem_ff <= 33'(div_r - {1'b0, dvs_ff});
                  quo_ff <= {quo_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= div_r[32:0];
                  quo_ff <= {quo_ff[30:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff + 1'b1;
            end
            OP_SET_AVG: begin
               avg_ff <= quo_ff;
            end
            OP_FIN_TRADE: begin
               // position clip, fill count and volume all raise saturation
               sat_ff <= sat_ff | (q_ff > Q_MAX) | (q_ff < Q_MIN)
                         | (fills_ff == 32'hFFFF_FFFF) | vol_sum[48];
               if (q_ff > Q_MAX) begin
                  q_ff <= Q_MAX;
               end else if (q_ff < Q_MIN) begin
                  q_ff <= Q_MIN;
               end
               if (fills_ff != 32'hFFFF_FFFF) begin
                  fills_ff <= fills_ff + 1'b1;
               end
               if (vol_sum[48]) begin
                  vol_ff <= '1;
               end else begin
                  vol_ff <= vol_sum[47:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE_RSP) begin
         rsp_ff.matched           <= matched_ff;
         rsp_ff.was_buy           <= matched_ff & buy_ff;
         rsp_ff.position_quantity <= q_ff[31:0];
         rsp_ff.average_price     <= avg_ff;
         rsp_ff.realized_profit   <= real_ff;
         rsp_ff.cash_balance      <= cash_ff;
         rsp_ff.fill_count        <= fills_ff;
         rsp_ff.traded_volume     <= vol_ff;
         rsp_ff.status            <= sat_ff ? STATUS_SAT : status_ff;
      end
   end

   assign rsp_data      = rsp_ff;
   assign stat.cmd      = item_ff.cmd;
   assign stat.qty_zero = (qty == '0);
   assign stat.found    = matched_ff;
   assign stat.miss     = !matched_ff && !pend_ff && (issue_ff == id_count_ff);
   assign stat.closing  = buy_ff ? q_ff[33] : (!q_ff[33] && q_ff != '0);
   assign stat.rest_nz  = (rest_ff != '0);
   assign stat.div_last = (div_cnt_ff == 5'd31);

endmodule

@@ rtl/average_cost_position_tracker.sv @@
// ----------------------------------------------------------------------------
// average_cost_position_tracker
// Own-id table with in-order scan, average-cost position and PnL keeping.
//
//  port group | dir | handshake            | payload
//  -----------+-----+----------------------+--------------------------
//  req_       | in  | req_valid/req_ready  | act_req_type command item
//  rsp_       | out | rsp_valid/rsp_ready  | act_rsp_type result item
//  csr_       | in  | csr_wr_en (no wait)  | 62-bit initial cash
//
// One item at a time. Add, clear and reset go from load through decode
// to the result write. A trade adds a scan and arithmetic: the scan reads
// the id memory one entry per cycle up to the hit, then the close steps
// when closing, close and rest steps when the close also opens the other
// side, or open steps and a 32-step radix-2 divider for the average price
// when opening. Synchronous reset clears the position, totals and id
// count; the id memory holds whatever it held. A stalled result holds its
// register, and the next item is taken as soon as the sequencer is idle.
// ----------------------------------------------------------------------------
module average_cost_position_tracker
   import act_pkg::*;
#(
   parameter int TABLE_DEPTH = 128
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  act_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output act_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [61:0] csr_wr_data
);

`include "average_cost_position_tracker_assert.svh"

   act_cmd_type  cmd;
   act_stat_type stat;

   // sequencer
   act_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // id memory, accumulators, multiplier and divider
   act_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_data    (rsp_data)
   );

   // an accepted item keeps the block busy for at least the next cycle
   `ACT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // a result write always shows up as a valid result
   `ACT_ASSERT_NEXT(a_write_gives_valid, clock, reset, cmd.op == OP_WRITE_RSP, rsp_valid)
   // the scan never reports a hit and a miss together
   `ACT_ASSERT_NOW(a_scan_exclusive, clock, reset, stat.found, !stat.miss)

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Average-cost position tracker regression
// Drives command items through the request channel, predicts every result
// from a local model of the own-id table and position book, and compares
// each result item field by field. Both channels idle at random, the result
// side holds off for a long stretch once, and the initial cash register is
// written between phases.
// ----------------------------------------------------------------------------
module testbench;
   import act_pkg::*;

   localparam int       TABLE_SLOTS = 128;
   localparam int       HOLD_LONG   = 500;
   localparam longint   POS_MAX     = 64'sd2147483647;
   localparam longint   POS_MIN     = -64'sd2147483648;
   localparam logic [63:0] VOL_CAP  = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [61:0] CASH_TOP = {62{1'b1}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   act_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   act_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [61:0] csr_wr_data = '0;

   always #5 clock = ~clock;

   average_cost_position_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // local copy of the book
   logic [61:0]        start_cash;
   logic [31:0]        own_ids[$];
   logic signed [31:0] held_qty;
   logic [31:0]        avg_px;
   logic signed [63:0] pnl_total;
   logic signed [63:0] cash_total;
   logic [31:0]        fills;
   logic [63:0]        volume;

   act_rsp_type expected_snapshots[$];
   int          fail_count;
   bit          quiet;          // no idling on either side while set
   bit          hold_off_req;   // asks the result side for one long stall

   function automatic void clear_book();
      own_ids.delete();
      held_qty   = '0;
      avg_px     = '0;
      pnl_total  = '0;
      cash_total = $signed({2'b00, start_cash});
      fills      = '0;
      volume     = '0;
   endfunction

   // saturating signed add; flags clipping
   function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   inout bit clipped);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         clipped = 1'b1;
         return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   // average-cost fill: close the opposite side first, then open/extend
   function automatic void book_fill(input bit buy, input logic signed [63:0] qty,
                                     input logic signed [63:0] px, inout bit clipped);
      logic signed [63:0] q, a, close, rest;
      logic [63:0]        total, mag;
      q = held_qty;
      a = $signed({32'd0, avg_px});
      if (buy && q < 0) begin
         close = (qty < -q) ? qty : -q;
         pnl_total  = add_clip(pnl_total, close * (a - px), clipped);
         // closing a short is charged at the trade price
         cash_total = add_clip(cash_total, -(close * px), clipped);
         q = q + close;
         if (qty > close) begin
            rest = qty - close;
            a = px;
            q = q + rest;
            cash_total = add_clip(cash_total, -(rest * px), clipped);
         end
      end else if (buy) begin
         total = q * a + qty * px;
         q = q + qty;
         mag = q;
         a = total / mag;
         cash_total = add_clip(cash_total, -(qty * px), clipped);
      end else if (q > 0) begin
         close = (qty < q) ? qty : q;
         pnl_total  = add_clip(pnl_total, close * (px - a), clipped);
         cash_total = add_clip(cash_total, close * px, clipped);
         q = q - close;
         if (qty > close) begin
            rest = qty - close;
            a = px;
            q = q - rest;
            cash_total = add_clip(cash_total, rest * px, clipped);
         end
      end else begin
         total = (-q) * a + qty * px;
         q = q - qty;
         mag = -q;
         a = total / mag;
         cash_total = add_clip(cash_total, qty * px, clipped);
      end
      if (q > POS_MAX) begin
         q = POS_MAX;
         clipped = 1'b1;
      end
      if (q < POS_MIN) begin
         q = POS_MIN;
         clipped = 1'b1;
      end
      held_qty = q[31:0];
      avg_px   = a[31:0];
      if (fills != 32'hFFFF_FFFF) fills = fills + 1;
      else clipped = 1'b1;
      volume = volume + qty;
      if (volume > VOL_CAP) begin
         volume  = VOL_CAP;
         clipped = 1'b1;
      end
   endfunction

   // applies one command to the local book and returns the snapshot it yields
   function automatic act_rsp_type track_command(input act_req_type r);
      act_rsp_type        o;
      logic signed [63:0] qty, px;
      bit                 hit, buy, clipped;
      qty = $signed({40'd0, r.trade_quantity});
      px  = $signed({32'd0, r.trade_price, 8'd0});
      hit = 1'b0;
      buy = 1'b0;
      clipped = 1'b0;
      o = '0;
      case (r.cmd)
         CMD_ADD_ID: begin
            if (own_ids.size() < TABLE_SLOTS) own_ids = {own_ids, r.own_order_id};
            else o.status = STATUS_FULL;
         end
         CMD_TRADE: begin
            if (qty != 0) begin
               // first table entry that names either side decides
               foreach (own_ids[i]) begin
                  if (!hit && own_ids[i] == r.buyer_order_id) begin
                     hit = 1'b1;
                     buy = 1'b1;
                  end else if (!hit && own_ids[i] == r.seller_order_id) begin
                     hit = 1'b1;
                  end
               end
               if (hit) book_fill(buy, qty, px, clipped);
            end
            if (clipped) o.status = STATUS_SAT;
         end
         CMD_CLEAR: own_ids.delete();
         default:   clear_book();
      endcase
      o.matched           = hit;
      o.was_buy           = hit && buy;
      o.position_quantity = held_qty;
      o.average_price     = avg_px;
      o.realized_profit   = pnl_total;
      o.cash_balance      = cash_total;
      o.fill_count        = fills;
      o.traded_volume     = volume[47:0];
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      act_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_snapshots.size() == 0) begin
            $error("result item with nothing expected");
            fail_count++;
         end else begin
            want = expected_snapshots.pop_front();
            check_field("matched", want.matched, rsp_data.matched);
            check_field("was_buy", want.was_buy, rsp_data.was_buy);
            check_field("position_quantity", want.position_quantity,
                        rsp_data.position_quantity);
            check_field("average_price", want.average_price, rsp_data.average_price);
            check_field("realized_profit", want.realized_profit,
                        rsp_data.realized_profit);
            check_field("cash_balance", want.cash_balance, rsp_data.cash_balance);
            check_field("fill_count", want.fill_count, rsp_data.fill_count);
            check_field("traded_volume", want.traded_volume, rsp_data.traded_volume);
            check_field("status", want.status, rsp_data.status);
         end
      end
   end

   // result side: random stall per item, one long hold-off on request
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         if (hold_off_req) begin
            wait_cycles  = HOLD_LONG;
            hold_off_req = 1'b0;
         end else begin
            wait_cycles = quiet ? 0 : $urandom_range(0, 17);
         end
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // sends one item; the prediction is queued at the accepting edge
   task automatic send_item(input act_req_type r);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      repeat (gap + 1) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      expected_snapshots.insert(expected_snapshots.size(), track_command(r));
      req_valid <= 1'b0;
   endtask

   function automatic act_req_type make_item(input logic [1:0] cmd,
                                             input logic [31:0] own,
                                             input logic [31:0] buyer,
                                             input logic [31:0] seller,
                                             input logic [23:0] qty,
                                             input logic [23:0] px);
      act_req_type r;
      r.cmd             = cmd;
      r.own_order_id    = own;
      r.buyer_order_id  = buyer;
      r.seller_order_id = seller;
      r.trade_quantity  = qty;
      r.trade_price     = px;
      return r;
   endfunction

   // every item yields a result, so idle means nothing outstanding
   task automatic wait_idle();
      while (expected_snapshots.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_start_cash(input logic [61:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      start_cash = v;     // only takes effect at the next reset command
   endtask

   task automatic test_directed();
      send_item(make_item(CMD_RESET, $urandom, $urandom, $urandom, 0, 0));
      send_item(make_item(CMD_ADD_ID, 32'h0000_0000, 0, 0, 0, 0));
      send_item(make_item(CMD_ADD_ID, 32'hFFFF_FFFF, 0, 0, 0, 0));
      send_item(make_item(CMD_ADD_ID, 32'h1234_5678, 0, 0, 0, 0));
      // zero quantity and foreign ids leave the book alone
      send_item(make_item(CMD_TRADE, 0, 32'h1234_5678, 7, 0, 500));
      send_item(make_item(CMD_TRADE, 0, 32'h55, 32'h66, 10, 500));
      // open long, add, partial close, flip short
      send_item(make_item(CMD_TRADE, 0, 32'h1234_5678, 9, 10, 1000));
      send_item(make_item(CMD_TRADE, 0, 32'hFFFF_FFFF, 9, 7, 1333));
      send_item(make_item(CMD_TRADE, 0, 9, 32'h0, 5, 1500));
      send_item(make_item(CMD_TRADE, 0, 9, 32'h0, 30, 900));
      // add to short, close short and flip long
      send_item(make_item(CMD_TRADE, 0, 9, 32'hFFFF_FFFF, 3, 777));
      send_item(make_item(CMD_TRADE, 0, 32'h0, 9, 40, 800));
      // both sides ours: earlier entry wins (seller listed first here)
      send_item(make_item(CMD_TRADE, 0, 32'h1234_5678, 32'h0, 4, 24'hFFFFFF));
      send_item(make_item(CMD_TRADE, 0, 32'h0, 32'h1234_5678, 4, 0));
      send_item(make_item(CMD_TRADE, 0, 32'hFFFF_FFFF, 9, 24'hFFFFFF, 24'hFFFFFF));
      send_item(make_item(CMD_TRADE, 0, 9, 32'hFFFF_FFFF, 24'hFFFFFF, 1));
      // clear keeps the position; the trade after it misses
      send_item(make_item(CMD_CLEAR, 0, 0, 0, 0, 0));
      send_item(make_item(CMD_TRADE, 0, 32'h0, 32'hFFFF_FFFF, 5, 5));
      send_item(make_item(CMD_RESET, 0, 0, 0, 0, 0));
   endtask

   task automatic test_table_full();
      send_item(make_item(CMD_RESET, 0, 0, 0, 0, 0));
      repeat (TABLE_SLOTS + 3) send_item(make_item(CMD_ADD_ID, $urandom, 0, 0, 0, 0));
      // hit on the last entry and on the first entry
      send_item(make_item(CMD_TRADE, 0, own_ids[TABLE_SLOTS-1], 1, 3, 100));
      send_item(make_item(CMD_TRADE, 0, own_ids[0], 1, 3, 100));
   endtask

   // drives position, cash and PnL into their limits
   task automatic test_saturation();
      send_item(make_item(CMD_RESET, 0, 0, 0, 0, 0));
      send_item(make_item(CMD_ADD_ID, 32'hA5A5_0001, 0, 0, 0, 0));
      repeat (140) send_item(make_item(CMD_TRADE, 0, 1, 32'hA5A5_0001,
                                       24'hFFFFFF, 24'hFFFFFF));
      repeat (140) send_item(make_item(CMD_TRADE, 0, 32'hA5A5_0001, 1, 24'hFFFFFF, 0));
   endtask

   function automatic logic [31:0] pick_id();
      if (own_ids.size() != 0 && $urandom_range(0, 3) != 0)
         return own_ids[$urandom_range(0, own_ids.size() - 1)];
      return $urandom;
   endfunction

   function automatic act_req_type random_item();
      int          roll;
      logic [23:0] qty, px;
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
         0:       qty = 24'($urandom_range(0, 24'hFFFFFF));
         1:       qty = 24'hFFFFFF;
         2:       qty = 24'd0;
         default: qty = 24'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 5))
         0:       px = 24'($urandom_range(0, 24'hFFFFFF));
         1:       px = 24'hFFFFFF;
         2:       px = 24'd0;
         default: px = 24'($urandom_range(1, 20000));
      endcase
      if (roll < 10 || own_ids.size() == 0)
         return make_item(CMD_ADD_ID, $urandom, $urandom, $urandom, qty, px);
      if (roll < 12) return make_item(CMD_CLEAR, $urandom, $urandom, $urandom, qty, px);
      if (roll < 13) return make_item(CMD_RESET, $urandom, $urandom, $urandom, qty, px);
      return make_item(CMD_TRADE, $urandom, pick_id(), pick_id(), qty, px);
   endfunction

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
         send_item(random_item());
      end
      quiet = 1'b0;
   endtask

   // result side stalls long while the sender keeps offering items
   task automatic test_backpressure();
      hold_off_req = 1'b1;
      quiet = 1'b1;
      repeat (30) send_item(random_item());
      quiet = 1'b0;
   endtask

   initial begin
      fail_count   = 0;
      quiet        = 1'b0;
      hold_off_req = 1'b0;
      start_cash   = '0;
      clear_book();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      write_start_cash(CASH_TOP);
      test_saturation();
      write_start_cash(62'({$urandom, $urandom} >> 2));
      send_item(make_item(CMD_RESET, 0, 0, 0, 0, 0));
      test_table_full();
      test_random(450);
      test_backpressure();
      write_start_cash('0);
      send_item(make_item(CMD_RESET, 0, 0, 0, 0, 0));
      test_random(450);
      wait_idle();
      repeat (100) @(posedge clock);
      if (expected_snapshots.size() != 0) begin
         $error("%0d result items never arrived", expected_snapshots.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("average_cost_position_tracker regression: pass");
      end else begin
         $display("average_cost_position_tracker regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("average_cost_position_tracker regression: fail");
      $finish;
   end

endmodule
